### sv/gru_pkg.sv
// ----------------------------------------------------------------------------
// gru_pkg
// Shared widths, latencies and request codes for the Givens rotation unit.
// ----------------------------------------------------------------------------
package gru_pkg;

    // Data is signed Q16.16, coefficients are signed Q2.30
    localparam int DATA_W          = 32;
    localparam int COEF_W          = 32;
    localparam int FRAC_BITS       = 30;
    localparam int INDEX_WIDTH_DEF = 12;

    // Generate path widths
    localparam int SQ_W   = 2 * DATA_W;       // sum of squares
    localparam int ROOT_W = DATA_W;           // integer square root
    localparam int QUO_W  = FRAC_BITS + 1;    // coefficient magnitude
    localparam int DIVD_W = DATA_W + FRAC_BITS;

    // Stage counts of each unit
    localparam int NORM_LAT  = 5;
    localparam int SQRT_LAT  = ROOT_W;
    localparam int DIV_LAT   = QUO_W + 1;
    localparam int APPLY_LAT = 3;
    localparam int PIPE_LAT  = NORM_LAT + SQRT_LAT + DIV_LAT;

    // Request codes
    localparam logic REQ_GENERATE = 1'b0;
    localparam logic REQ_APPLY    = 1'b1;

    // 1.0 and -1.0 in Q2.30
    localparam logic signed [COEF_W-1:0] COEF_ONE     = 32'sh4000_0000;
    localparam logic signed [COEF_W-1:0] COEF_NEG_ONE = -32'sh4000_0000;

    typedef logic [DATA_W-1:0] mag_t;

endpackage

### sv/givens_rotation_unit.sv
// ----------------------------------------------------------------------------
// givens_rotation_unit
// Generates rotation coefficients from a pair or applies a rotation to a pair.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_type, values, c, s, indices, last
//   res      out        res_valid/res_stall  rot_first/second, cos/sin_out, echoes
//
// One transaction enters per cycle while req_stall is low; each request passes
// through 5 normalize stages, 32 square-root stages, 32 divider stages and the
// output register.
// Reset clears the valid bits only. A result arriving behind a stalled output
// moves into a skid register; req_stall rises only while that skid register is full.
// ----------------------------------------------------------------------------
module givens_rotation_unit
#(
    parameter int INDEX_WIDTH = gru_pkg::INDEX_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic                              req_type,
    input  logic signed [gru_pkg::DATA_W-1:0] first_value,
    input  logic signed [gru_pkg::DATA_W-1:0] second_value,
    input  logic signed [gru_pkg::COEF_W-1:0] cos_value,
    input  logic signed [gru_pkg::COEF_W-1:0] sin_value,
    input  logic        [INDEX_WIDTH-1:0]     first_index,
    input  logic        [INDEX_WIDTH-1:0]     second_index,
    input  logic                              last_pair,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic signed [gru_pkg::DATA_W-1:0] rot_first,
    output logic signed [gru_pkg::DATA_W-1:0] rot_second,
    output logic signed [gru_pkg::COEF_W-1:0] cos_out,
    output logic signed [gru_pkg::COEF_W-1:0] sin_out,
    output logic        [INDEX_WIDTH-1:0]     first_index_out,
    output logic        [INDEX_WIDTH-1:0]     second_index_out,
    output logic                              last_out
);
    import gru_pkg::*;

    typedef struct packed {
        logic                   apply;
        logic [INDEX_WIDTH-1:0] idx_a;
        logic [INDEX_WIDTH-1:0] idx_b;
        logic                   last;
        logic                   neg_x;
        logic                   neg_y;
        logic                   zero;
        logic [DATA_W-1:0]      rf;
        logic [DATA_W-1:0]      rs;
    } tag_t;

    typedef struct packed {
        logic [DATA_W-1:0]      rf;
        logic [DATA_W-1:0]      rs;
        logic [COEF_W-1:0]      co;
        logic [COEF_W-1:0]      so;
        logic [INDEX_WIDTH-1:0] idx_a;
        logic [INDEX_WIDTH-1:0] idx_b;
        logic                   last;
    } res_t;

    logic en;

    logic [PIPE_LAT-1:0] vld_reg;
    tag_t                tag_reg [PIPE_LAT];
    tag_t                tag_src [PIPE_LAT];

    logic [DATA_W-1:0]   ax_n, ay_n;
    logic [SQ_W-1:0]     sum_sq;
    logic [ROOT_W-1:0]   norm;
    logic [2*DATA_W-1:0] aux_out;
    logic [QUO_W-1:0]    quo_c, quo_s;
    logic signed [DATA_W-1:0] app_rf, app_rs;

    tag_t fin_tag;
    res_t fin;
    logic [COEF_W-1:0] mag_c, mag_s;

    logic res_valid_reg, skid_vld_reg;
    res_t res_reg, skid_reg;

    // Advance the whole pipeline unless the skid register is full
    assign en        = !skid_vld_reg;
    assign req_stall = skid_vld_reg;

    gru_norm u_norm
    (
        .clk    (clk),
        .en     (en),
        .x      (first_value),
        .y      (second_value),
        .ax_out (ax_n),
        .ay_out (ay_n),
        .sum_sq (sum_sq)
    );

    gru_sqrt u_sqrt
    (
        .clk      (clk),
        .en       (en),
        .radicand (sum_sq),
        .aux_in   ({ax_n, ay_n}),
        .root     (norm),
        .aux_out  (aux_out)
    );

    gru_div u_div_c
    (
        .clk (clk),
        .en  (en),
        .num (aux_out[2*DATA_W-1:DATA_W]),
        .den (norm),
        .quo (quo_c)
    );

    gru_div u_div_s
    (
        .clk (clk),
        .en  (en),
        .num (aux_out[DATA_W-1:0]),
        .den (norm),
        .quo (quo_s)
    );

    gru_apply u_apply
    (
        .clk (clk),
        .en  (en),
        .a   (first_value),
        .b   (second_value),
        .c   (cos_value),
        .s   (sin_value),
        .rf  (app_rf),
        .rs  (app_rs)
    );

    // Build the tag line; apply results join once they are ready
    always_comb
    begin
        tag_src[0].apply = (req_type == REQ_APPLY);
        tag_src[0].idx_a = first_index;
        tag_src[0].idx_b = second_index;
        tag_src[0].last  = last_pair;
        tag_src[0].neg_x = first_value[DATA_W-1];
        tag_src[0].neg_y = second_value[DATA_W-1];
        tag_src[0].zero  = (first_value == '0) && (second_value == '0);
        tag_src[0].rf    = '0;
        tag_src[0].rs    = '0;
        for (int i = 1; i < PIPE_LAT; i++)
        begin
            tag_src[i] = tag_reg[i-1];
        end
        tag_src[APPLY_LAT].rf = app_rf;
        tag_src[APPLY_LAT].rs = app_rs;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < PIPE_LAT; i++)
            begin
                tag_reg[i] <= tag_src[i];
            end
        end
    end

    // Move valid bits with the tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], req_valid};
        end
    end

    // Sign the coefficients and pick the fields of the request kind
    assign fin_tag = tag_reg[PIPE_LAT-1];
    assign mag_c   = COEF_W'(quo_c);
    assign mag_s   = COEF_W'(quo_s);

    always_comb
    begin
        fin.idx_a = fin_tag.idx_a;
        fin.idx_b = fin_tag.idx_b;
        fin.last  = fin_tag.last;
        if (fin_tag.apply)
        begin
            fin.rf = fin_tag.rf;
            fin.rs = fin_tag.rs;
            fin.co = '0;
            fin.so = '0;
        end
        else
        begin
            fin.rf = '0;
            fin.rs = '0;
            if (fin_tag.zero)
            begin
                fin.co = COEF_ONE;
                fin.so = '0;
            end
            else
            begin
                fin.co = fin_tag.neg_x ? -mag_c : mag_c;
                fin.so = fin_tag.neg_y ? -mag_s : mag_s;
            end
        end
    end

    // Output register and skid: hold on stall, drain the skid first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            skid_vld_reg  <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (!res_stall)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (!res_valid_reg || !res_stall)
        begin
            res_valid_reg <= vld_reg[PIPE_LAT-1];
        end
        else if (vld_reg[PIPE_LAT-1])
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (!res_stall)
            begin
                res_reg <= skid_reg;
            end
        end
        else if (!res_valid_reg || !res_stall)
        begin
            res_reg <= fin;
        end
        else
        begin
            skid_reg <= fin;
        end
    end

    assign res_valid        = res_valid_reg;
    assign rot_first        = $signed(res_reg.rf);
    assign rot_second       = $signed(res_reg.rs);
    assign cos_out          = $signed(res_reg.co);
    assign sin_out          = $signed(res_reg.so);
    assign first_index_out  = res_reg.idx_a;
    assign second_index_out = res_reg.idx_b;
    assign last_out         = res_reg.last;

    // A full skid register always sits behind a valid output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> res_valid_reg)
        else $error("skid register full while output empty");

    // The skid fills only when a valid output was stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(res_valid_reg && res_stall))
        else $error("skid filled without a stalled output");

    // Generated coefficients stay within one in magnitude
    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (cos_out <= COEF_ONE && cos_out >= COEF_NEG_ONE))
        else $error("cosine out of range");

    a_sin_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (sin_out <= COEF_ONE && sin_out >= COEF_NEG_ONE))
        else $error("sine out of range");

endmodule

### sv/gru_norm.sv
// ----------------------------------------------------------------------------
// gru_norm
// Magnitudes, joint normalization so the larger lands on bit 30 (or 31),
// then the sum of squares. Five register stages.
// ----------------------------------------------------------------------------
module gru_norm
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [gru_pkg::DATA_W-1:0] x,
    input  logic signed [gru_pkg::DATA_W-1:0] y,
    output logic        [gru_pkg::DATA_W-1:0] ax_out,
    output logic        [gru_pkg::DATA_W-1:0] ay_out,
    output logic        [gru_pkg::SQ_W-1:0]   sum_sq
);
    import gru_pkg::*;

    localparam int MSB = DATA_W - 1;

    mag_t ax1_reg, ay1_reg, m1_reg;
    mag_t ax2_reg, ay2_reg, m2_reg;
    mag_t ax3_reg, ay3_reg;
    mag_t ax4_reg, ay4_reg;
    mag_t ax5_reg, ay5_reg;
    logic [SQ_W-1:0] sqx_reg, sqy_reg, sum_reg;

    mag_t ax1_next, ay1_next, m1_next;
    mag_t ax16, ay16, m16;
    mag_t ax2_next, ay2_next, m2_next;
    mag_t ax4s, ay4s, m4s;
    mag_t ax2s, ay2s, m2s;
    mag_t ax3_next, ay3_next;
    logic [SQ_W-1:0] sqx_next, sqy_next, sum_next;

    // Take magnitudes and the larger of the two
    always_comb
    begin
        ax1_next = x[MSB] ? mag_t'(-x) : mag_t'(x);
        ay1_next = y[MSB] ? mag_t'(-y) : mag_t'(y);
        m1_next  = (ax1_next > ay1_next) ? ax1_next : ay1_next;
    end

    // Shift by 16 and 8 where the leading zeros allow
    always_comb
    begin
        if (m1_reg[MSB:15] == '0)
        begin
            ax16 = ax1_reg << 16;
            ay16 = ay1_reg << 16;
            m16  = m1_reg << 16;
        end
        else
        begin
            ax16 = ax1_reg;
            ay16 = ay1_reg;
            m16  = m1_reg;
        end
        if (m16[MSB:23] == '0)
        begin
            ax2_next = ax16 << 8;
            ay2_next = ay16 << 8;
            m2_next  = m16 << 8;
        end
        else
        begin
            ax2_next = ax16;
            ay2_next = ay16;
            m2_next  = m16;
        end
    end

    // Finish with shifts by 4, 2 and 1
    always_comb
    begin
        if (m2_reg[MSB:27] == '0)
        begin
            ax4s = ax2_reg << 4;
            ay4s = ay2_reg << 4;
            m4s  = m2_reg << 4;
        end
        else
        begin
            ax4s = ax2_reg;
            ay4s = ay2_reg;
            m4s  = m2_reg;
        end
        if (m4s[MSB:29] == '0)
        begin
            ax2s = ax4s << 2;
            ay2s = ay4s << 2;
            m2s  = m4s << 2;
        end
        else
        begin
            ax2s = ax4s;
            ay2s = ay4s;
            m2s  = m4s;
        end
        if (m2s[MSB:30] == '0)
        begin
            ax3_next = ax2s << 1;
            ay3_next = ay2s << 1;
        end
        else
        begin
            ax3_next = ax2s;
            ay3_next = ay2s;
        end
    end

    // Square and sum
    always_comb
    begin
        sqx_next = {{DATA_W{1'b0}}, ax3_reg} * {{DATA_W{1'b0}}, ax3_reg};
        sqy_next = {{DATA_W{1'b0}}, ay3_reg} * {{DATA_W{1'b0}}, ay3_reg};
        sum_next = sqx_reg + sqy_reg;
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg <= ax1_next;
            ay1_reg <= ay1_next;
            m1_reg  <= m1_next;
            ax2_reg <= ax2_next;
            ay2_reg <= ay2_next;
            m2_reg  <= m2_next;
            ax3_reg <= ax3_next;
            ay3_reg <= ay3_next;
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            ax4_reg <= ax3_reg;
            ay4_reg <= ay3_reg;
            sum_reg <= sum_next;
            ax5_reg <= ax4_reg;
            ay5_reg <= ay4_reg;
        end
    end

    assign ax_out = ax5_reg;
    assign ay_out = ay5_reg;
    assign sum_sq = sum_reg;

endmodule

### sv/gru_sqrt.sv
// ----------------------------------------------------------------------------
// gru_sqrt
// Pipelined integer square root, one result bit per stage, with the scaled
// magnitudes carried alongside.
// ----------------------------------------------------------------------------
module gru_sqrt
(
    input  logic                              clk,
    input  logic                              en,
    input  logic [gru_pkg::SQ_W-1:0]          radicand,
    input  logic [2*gru_pkg::DATA_W-1:0]      aux_in,
    output logic [gru_pkg::ROOT_W-1:0]        root,
    output logic [2*gru_pkg::DATA_W-1:0]      aux_out
);
    import gru_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int CUR_W = ROOT_W + 4;
    localparam int AUX_W = 2 * DATA_W;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SQ_W-1:0]   rad_reg  [ROOT_W];
    logic [AUX_W-1:0]  aux_reg  [ROOT_W];

    logic [REM_W-1:0]  rem_src  [ROOT_W];
    logic [ROOT_W-1:0] root_src [ROOT_W];
    logic [SQ_W-1:0]   rad_src  [ROOT_W];
    logic [AUX_W-1:0]  aux_src  [ROOT_W];

    logic [REM_W-1:0]  rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];

    logic [CUR_W-1:0]  cur   [ROOT_W];
    logic [CUR_W-1:0]  trial [ROOT_W];

    // Select each stage's source
    always_comb
    begin
        rem_src[0]  = '0;
        root_src[0] = '0;
        rad_src[0]  = radicand;
        aux_src[0]  = aux_in;
        for (int k = 1; k < ROOT_W; k++)
        begin
            rem_src[k]  = rem_reg[k-1];
            root_src[k] = root_reg[k-1];
            rad_src[k]  = rad_reg[k-1];
            aux_src[k]  = aux_reg[k-1];
        end
    end

    // Bring down two radicand bits and try the next root bit
    always_comb
    begin
        for (int k = 0; k < ROOT_W; k++)
        begin
            cur[k]   = {rem_src[k], rad_src[k][SQ_W-1 -: 2]};
            trial[k] = {2'b00, root_src[k], 2'b01};
            if (cur[k] >= trial[k])
            begin
                rem_next[k]  = REM_W'(cur[k] - trial[k]);
                root_next[k] = {root_src[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = REM_W'(cur[k]);
                root_next[k] = {root_src[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ROOT_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_src[k] << 2;
                aux_reg[k]  <= aux_src[k];
            end
        end
    end

    assign root    = root_reg[ROOT_W-1];
    assign aux_out = aux_reg[ROOT_W-1];

endmodule

### sv/gru_div.sv
// ----------------------------------------------------------------------------
// gru_div
// Pipelined restoring divider for one coefficient: (num * 2^30 + den/2) / den,
// one prepare stage and one quotient bit per stage after it.
// ----------------------------------------------------------------------------
module gru_div
(
    input  logic                           clk,
    input  logic                           en,
    input  logic [gru_pkg::DATA_W-1:0]     num,
    input  logic [gru_pkg::ROOT_W-1:0]     den,
    output logic [gru_pkg::QUO_W-1:0]      quo
);
    import gru_pkg::*;

    localparam int REM_W = ROOT_W;
    localparam int CUR_W = ROOT_W + 1;

    logic [DIVD_W-1:0] divd;

    logic [REM_W-1:0]  prem_reg;
    logic [QUO_W-1:0]  plow_reg;
    logic [ROOT_W-1:0] pden_reg;

    logic [REM_W-1:0]  rem_reg [QUO_W];
    logic [QUO_W-1:0]  low_reg [QUO_W];
    logic [ROOT_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0]  quo_reg [QUO_W];

    logic [REM_W-1:0]  rem_src [QUO_W];
    logic [QUO_W-1:0]  low_src [QUO_W];
    logic [ROOT_W-1:0] den_src [QUO_W];
    logic [QUO_W-1:0]  quo_src [QUO_W];

    logic [CUR_W-1:0]  cur      [QUO_W];
    logic [REM_W-1:0]  rem_next [QUO_W];
    logic [QUO_W-1:0]  quo_next [QUO_W];

    // Form the rounded dividend; its top bits start below den
    assign divd = {num, {FRAC_BITS{1'b0}}} + DIVD_W'(den >> 1);

    // Select each stage's source
    always_comb
    begin
        rem_src[0] = prem_reg;
        low_src[0] = plow_reg;
        den_src[0] = pden_reg;
        quo_src[0] = '0;
        for (int k = 1; k < QUO_W; k++)
        begin
            rem_src[k] = rem_reg[k-1];
            low_src[k] = low_reg[k-1];
            den_src[k] = den_reg[k-1];
            quo_src[k] = quo_reg[k-1];
        end
    end

    // Shift in one dividend bit and subtract where it fits
    always_comb
    begin
        for (int k = 0; k < QUO_W; k++)
        begin
            cur[k] = {rem_src[k], low_src[k][QUO_W-1]};
            if (cur[k] >= {1'b0, den_src[k]})
            begin
                rem_next[k] = REM_W'(cur[k] - {1'b0, den_src[k]});
                quo_next[k] = {quo_src[k][QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = REM_W'(cur[k]);
                quo_next[k] = {quo_src[k][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prem_reg <= REM_W'(divd[DIVD_W-1:QUO_W]);
            plow_reg <= divd[QUO_W-1:0];
            pden_reg <= den;
            for (int k = 0; k < QUO_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_src[k] << 1;
                den_reg[k] <= den_src[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

### sv/gru_apply.sv
// ----------------------------------------------------------------------------
// gru_apply
// Rotation of one element pair: products, rounded sums, saturation.
// Three register stages.
// ----------------------------------------------------------------------------
module gru_apply
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [gru_pkg::DATA_W-1:0] a,
    input  logic signed [gru_pkg::DATA_W-1:0] b,
    input  logic signed [gru_pkg::COEF_W-1:0] c,
    input  logic signed [gru_pkg::COEF_W-1:0] s,
    output logic signed [gru_pkg::DATA_W-1:0] rf,
    output logic signed [gru_pkg::DATA_W-1:0] rs
);
    import gru_pkg::*;

    localparam int PROD_W = DATA_W + COEF_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int T_W    = SUM_W - FRAC_BITS;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic signed [PROD_W-1:0] pca_reg, psb_reg, psa_reg, pcb_reg;
    logic signed [SUM_W-1:0]  sum1_reg, sum2_reg;
    logic signed [DATA_W-1:0] rf_reg, rs_reg;

    logic signed [SUM_W-1:0]  sum1_next, sum2_next;
    logic signed [DATA_W-1:0] rf_next, rs_next;
    logic        [T_W-1:0]    t1, t2;

    // Add the products and the rounding half
    always_comb
    begin
        sum1_next = $signed({{2{pca_reg[PROD_W-1]}}, pca_reg})
                  + $signed({{2{psb_reg[PROD_W-1]}}, psb_reg}) + ROUND_HALF;
        sum2_next = $signed({{2{pcb_reg[PROD_W-1]}}, pcb_reg})
                  - $signed({{2{psa_reg[PROD_W-1]}}, psa_reg}) + ROUND_HALF;
    end

    // Drop the fraction and saturate
    always_comb
    begin
        t1 = sum1_reg[SUM_W-1:FRAC_BITS];
        t2 = sum2_reg[SUM_W-1:FRAC_BITS];
        if (t1[T_W-1:DATA_W-1] == '0 || t1[T_W-1:DATA_W-1] == '1)
            rf_next = $signed(t1[DATA_W-1:0]);
        else
            rf_next = t1[T_W-1] ? SAT_MIN : SAT_MAX;
        if (t2[T_W-1:DATA_W-1] == '0 || t2[T_W-1:DATA_W-1] == '1)
            rs_next = $signed(t2[DATA_W-1:0]);
        else
            rs_next = t2[T_W-1] ? SAT_MIN : SAT_MAX;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pca_reg  <= c * a;
            psb_reg  <= s * b;
            psa_reg  <= s * a;
            pcb_reg  <= c * b;
            sum1_reg <= sum1_next;
            sum2_reg <= sum2_next;
            rf_reg   <= rf_next;
            rs_reg   <= rs_next;
        end
    end

    assign rf = rf_reg;
    assign rs = rs_reg;

endmodule

### bench/tb_givens_rotation_unit.sv
// ----------------------------------------------------------------------------
// tb_givens_rotation_unit
// Self-checking bench for the Givens rotation unit. Generate and apply
// requests are streamed under several idle and stall mixes, including a long
// receiver hold-off. Every accepted result is compared field by field with a
// bit-exact prediction of the coefficients or the rotated pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_givens_rotation_unit;

    import gru_pkg::*;

    localparam int IDX_W     = INDEX_WIDTH_DEF;
    localparam int DRAIN_CYC = PIPE_LAT + 20;
    localparam int WD_LIMIT  = 5000;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] s;
        logic [IDX_W-1:0]         i1;
        logic [IDX_W-1:0]         i2;
        logic                     last;
    } rot_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] r1;
        logic signed [DATA_W-1:0] r2;
        logic signed [COEF_W-1:0] co;
        logic signed [COEF_W-1:0] so;
        logic [IDX_W-1:0]         i1;
        logic [IDX_W-1:0]         i2;
        logic                     last;
    } rot_res_t;

    logic                     clk;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    logic                     req_type;
    logic signed [DATA_W-1:0] first_value;
    logic signed [DATA_W-1:0] second_value;
    logic signed [COEF_W-1:0] cos_value;
    logic signed [COEF_W-1:0] sin_value;
    logic [IDX_W-1:0]         first_index;
    logic [IDX_W-1:0]         second_index;
    logic                     last_pair;
    logic                     res_valid;
    logic                     res_stall;
    logic signed [DATA_W-1:0] rot_first;
    logic signed [DATA_W-1:0] rot_second;
    logic signed [COEF_W-1:0] cos_out;
    logic signed [COEF_W-1:0] sin_out;
    logic [IDX_W-1:0]         first_index_out;
    logic [IDX_W-1:0]         second_index_out;
    logic                     last_out;

    rot_res_t pending_results[$];
    int       fail_count;
    int       send_idle_pct;
    int       stall_pct;
    int       hold_off_cycles;
    int       quiet_cycles;

    givens_rotation_unit #(.INDEX_WIDTH(IDX_W)) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .req_type         (req_type),
        .first_value      (first_value),
        .second_value     (second_value),
        .cos_value        (cos_value),
        .sin_value        (sin_value),
        .first_index      (first_index),
        .second_index     (second_index),
        .last_pair        (last_pair),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .rot_first        (rot_first),
        .rot_second       (rot_second),
        .cos_out          (cos_out),
        .sin_out          (sin_out),
        .first_index_out  (first_index_out),
        .second_index_out (second_index_out),
        .last_out         (last_out)
    );

    // Generate the clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Integer square root, bit by bit
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Round half up and saturate a Q2.30-scaled sum of products to Q16.16
    function automatic logic signed [DATA_W-1:0] round_sat(
        input logic signed [65:0] p1, input logic signed [65:0] p2);
        logic signed [65:0] t;
        t = (p1 + p2 + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (t > 66'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (t < -66'sh8000_0000)
            return 32'sh8000_0000;
        return t[DATA_W-1:0];
    endfunction

    // Scale a magnitude by the norm into a signed Q2.30 coefficient
    function automatic logic signed [COEF_W-1:0] coef_of(
        input longint unsigned num, input longint unsigned n, input logic neg);
        longint unsigned q;
        q = ((num << FRAC_BITS) + (n >> 1)) / n;
        return neg ? -q[COEF_W-1:0] : q[COEF_W-1:0];
    endfunction

    // Work out the result that one request produces
    function automatic rot_res_t rotate_predict(input rot_req_t r);
        rot_res_t          o;
        longint unsigned   ax;
        longint unsigned   ay;
        longint unsigned   m;
        longint unsigned   n;
        logic signed [65:0] a;
        logic signed [65:0] b;
        logic signed [65:0] c;
        logic signed [65:0] s;
        o      = '0;
        o.i1   = r.i1;
        o.i2   = r.i2;
        o.last = r.last;
        a = r.a;
        b = r.b;
        c = r.c;
        s = r.s;
        if (r.kind == REQ_GENERATE)
        begin
            ax = (a < 0) ? longint'(-a) : longint'(a);
            ay = (b < 0) ? longint'(-b) : longint'(b);
            m  = (ax > ay) ? ax : ay;
            if (m == 0)
                o.co = COEF_ONE;
            else
            begin
                while (m < (64'd1 << 30))
                begin
                    ax = ax << 1;
                    ay = ay << 1;
                    m  = m << 1;
                end
                n    = int_sqrt(ax * ax + ay * ay);
                o.co = coef_of(ax, n, a < 0);
                o.so = coef_of(ay, n, b < 0);
            end
        end
        else
        begin
            o.r1 = round_sat(c * a, s * b);
            o.r2 = round_sat(-s * a, c * b);
        end
        return o;
    endfunction

    // Offer one request, hold it until accepted, then idle cycle by cycle
    task automatic send_request(input rot_req_t r);
        req_valid    <= 1'b1;
        req_type     <= r.kind;
        first_value  <= r.a;
        second_value <= r.b;
        cos_value    <= r.c;
        sin_value    <= r.s;
        first_index  <= r.i1;
        second_index <= r.i2;
        last_pair    <= r.last;
        do
            @(posedge clk);
        while (req_stall);
        pending_results.push_back(rotate_predict(r));
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Drive the receiver stall, with an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            res_stall       <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            res_stall <= ($urandom_range(99) < stall_pct);
    end

    // Check each result transaction against the oldest prediction
    always @(posedge clk)
    begin
        rot_res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result transaction", $time);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rot_first !== want.r1)
                begin
                    $display("%0t: rot_first exp %h got %h", $time, want.r1, rot_first);
                    fail_count++;
                end
                if (rot_second !== want.r2)
                begin
                    $display("%0t: rot_second exp %h got %h", $time, want.r2, rot_second);
                    fail_count++;
                end
                if (cos_out !== want.co)
                begin
                    $display("%0t: cos_out exp %h got %h", $time, want.co, cos_out);
                    fail_count++;
                end
                if (sin_out !== want.so)
                begin
                    $display("%0t: sin_out exp %h got %h", $time, want.so, sin_out);
                    fail_count++;
                end
                if (first_index_out !== want.i1)
                begin
                    $display("%0t: first_index_out exp %h got %h", $time, want.i1,
                             first_index_out);
                    fail_count++;
                end
                if (second_index_out !== want.i2)
                begin
                    $display("%0t: second_index_out exp %h got %h", $time, want.i2,
                             second_index_out);
                    fail_count++;
                end
                if (last_out !== want.last)
                begin
                    $display("%0t: last_out exp %h got %h", $time, want.last, last_out);
                    fail_count++;
                end
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else if (req_valid || pending_results.size() != 0)
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic rot_req_t make_req(input logic kind,
        input logic [31:0] a, input logic [31:0] b,
        input logic [31:0] c, input logic [31:0] s);
        rot_req_t r;
        r.kind = kind;
        r.a    = a;
        r.b    = b;
        r.c    = c;
        r.s    = s;
        r.i1   = IDX_W'($urandom);
        r.i2   = IDX_W'($urandom);
        r.last = 1'($urandom_range(1));
        return r;
    endfunction

    // Pick a data value: extremes, small magnitudes or anything
    function automatic logic [31:0] rand_data();
        unique case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return $urandom_range(8) - 4;
            3: return $urandom >> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // Pick a coefficient, mostly within [-1.0, 1.0]
    function automatic logic [31:0] rand_coef();
        unique case ($urandom_range(7))
            0: return COEF_ONE;
            1: return COEF_NEG_ONE;
            2: return $urandom;
            default: return $urandom_range(32'h8000_0000) - 32'h4000_0000;
        endcase
    endfunction

    task automatic wait_drain();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC)
            @(posedge clk);
    endtask

    // Extremes, zero norm, identity, saturation and odd coefficients
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_request(make_req(REQ_GENERATE, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_req(REQ_GENERATE, 32'h8000_0000, 0, 0, 0));
        send_request(make_req(REQ_GENERATE, 32'h8000_0000, 32'h8000_0000, 0, 0));
        send_request(make_req(REQ_GENERATE, 0, 32'h8000_0000, 0, 0));
        send_request(make_req(REQ_GENERATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
        send_request(make_req(REQ_GENERATE, 1, 0, 0, 0));
        send_request(make_req(REQ_GENERATE, 32'hFFFF_FFFF, 1, 0, 0));
        send_request(make_req(REQ_GENERATE, 3, 4, 0, 0));
        send_request(make_req(REQ_GENERATE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
        send_request(make_req(REQ_APPLY, 32'h0001_0000, 32'h0002_0000, COEF_ONE, 0));
        send_request(make_req(REQ_APPLY, 32'h8000_0000, 32'h8000_0000,
                              COEF_NEG_ONE, COEF_NEG_ONE));
        send_request(make_req(REQ_APPLY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, COEF_ONE, COEF_ONE));
        send_request(make_req(REQ_APPLY, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h8000_0000, 32'h8000_0000));
        send_request(make_req(REQ_APPLY, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_request(make_req(REQ_APPLY, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
        send_request(make_req(REQ_APPLY, 1, 32'hFFFF_FFFF, 32'h2000_0000, 32'h2000_0000));
        send_request('{REQ_APPLY, 5, 7, 32'h2D41_3CCD, 32'h2D41_3CCD, '1, '1, 1'b1});
        send_request('{REQ_GENERATE, 5, 7, 0, 0, '0, '0, 1'b0});
        wait_drain();
    endtask

    // Random stream: a generate followed by a run of apply pairs, plus noise
    task automatic test_random(input int items, input int idle_pct, input int stl_pct);
        rot_req_t r;
        rot_res_t g;
        int       sent;
        int       run;
        send_idle_pct = idle_pct;
        stall_pct     = stl_pct;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(3) == 0)
            begin
                r = make_req(1'($urandom_range(1)), rand_data(), rand_data(),
                             rand_coef(), rand_coef());
                send_request(r);
                sent++;
            end
            else
            begin
                r = make_req(REQ_GENERATE, rand_data(), rand_data(), $urandom, $urandom);
                g = rotate_predict(r);
                send_request(r);
                sent++;
                run = $urandom_range(1, 8);
                for (int k = 0; k < run; k++)
                begin
                    r = make_req(REQ_APPLY, rand_data(), rand_data(), g.co, g.so);
                    r.i1   = IDX_W'(k);
                    r.i2   = IDX_W'(k + run);
                    r.last = (k == run - 1);
                    send_request(r);
                    sent++;
                end
            end
        end
        wait_drain();
    endtask

    // Hold off the receiver so the pipeline fills and stalls its input
    task automatic test_backpressure();
        send_idle_pct   = 0;
        stall_pct       = 0;
        hold_off_cycles = 300;
        for (int k = 0; k < 150; k++)
            send_request(make_req(1'($urandom_range(1)), rand_data(), rand_data(),
                                  rand_coef(), rand_coef()));
        wait_drain();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        req_type        = REQ_GENERATE;
        first_value     = '0;
        second_value    = '0;
        cos_value       = '0;
        sin_value       = '0;
        first_index     = '0;
        second_index    = '0;
        last_pair       = 1'b0;
        fail_count      = 0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        hold_off_cycles = 0;
        quiet_cycles    = 0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(180, 0, 0);
        test_random(180, 52, 0);
        test_random(180, 0, 52);
        test_random(180, 11, 11);
        test_backpressure();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
